FILE: src/vesh_pkg.sv
// ----------------------------------------------------------------------------
// vesh_pkg
// Types, constants and fixed-point helpers for the volumetric penalty unit.
// ----------------------------------------------------------------------------
package vesh_pkg;

	// input beat: F, row-major, signed Q8.24
	typedef struct packed {
		logic signed [31:0] f_r0c0;
		logic signed [31:0] f_r0c1;
		logic signed [31:0] f_r0c2;
		logic signed [31:0] f_r1c0;
		logic signed [31:0] f_r1c1;
		logic signed [31:0] f_r1c2;
		logic signed [31:0] f_r2c0;
		logic signed [31:0] f_r2c1;
		logic signed [31:0] f_r2c2;
	} in_item_t;

	// result beat: one row of stress or Hessian, Q24.40
	typedef struct packed {
		logic        [3:0]  row_index;
		logic signed [63:0] val0;
		logic signed [63:0] val1;
		logic signed [63:0] val2;
		logic signed [63:0] val3;
		logic signed [63:0] val4;
		logic signed [63:0] val5;
		logic signed [63:0] val6;
		logic signed [63:0] val7;
		logic signed [63:0] val8;
		logic signed [63:0] energy;
		logic               last_row;
	} out_item_t;

	localparam logic [3:0]  STRESS_ROW = 4'd0;
	localparam logic [3:0]  LAST_ROW   = 4'd9;
	localparam logic [31:0] SCALE_RST  = 32'd65536;

	// saturate a 128-bit signed value to 64 bits
	function automatic logic signed [63:0] sat128(input logic signed [127:0] x);
		logic signed [63:0] r;
		if (&x[127:63] || ~|x[127:63]) begin
			r = x[63:0];
		end else if (x[127]) begin
			r = {1'b1, 63'd0};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

	// round half up, then arithmetic shift right by k
	function automatic logic signed [127:0] rnd128(input logic signed [127:0] x,
			input int k);
		logic signed [127:0] h;
		h = 128'sd1 <<< (k - 1);
		return (x + h) >>> k;
	endfunction

	// (a + 1) mod 3 for a small index
	function automatic logic [1:0] next3(input logic [1:0] a);
		return (a == 2'd2) ? 2'd0 : a + 2'd1;
	endfunction

	// upper half of a 64-bit value, signed
	function automatic logic signed [32:0] hi33(input logic signed [63:0] x);
		return 33'(signed'(x[63:32]));
	endfunction

	// lower half of a 64-bit value, as a non-negative 33-bit operand
	function automatic logic signed [32:0] lo33(input logic signed [63:0] x);
		return signed'({1'b0, x[31:0]});
	endfunction

	// one 33x33 partial product
	function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
			input logic signed [32:0] b);
		return 66'(a) * 66'(b);
	endfunction

	// hi/lo partial products of a 64 x 33 product
	function automatic logic signed [127:0] join2(input logic signed [65:0] ph,
			input logic signed [65:0] pl);
		return (128'(ph) <<< 32) + 128'(pl);
	endfunction

	// four partial products of a 64 x 64 product
	function automatic logic signed [127:0] join4(input logic signed [65:0] hh,
			input logic signed [65:0] hl, input logic signed [65:0] lh,
			input logic signed [65:0] ll);
		return (128'(hh) <<< 64) + ((128'(hl) + 128'(lh)) <<< 32) + 128'(ll);
	endfunction

endpackage

FILE: src/volume_energy_stress_hessian_unit.sv
// ----------------------------------------------------------------------------
// volume_energy_stress_hessian_unit
// Volumetric penalty 0.5*s*(det F - 1)^2: stress row and nine Hessian rows.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  item     | item_valid/item_stall  | item  (F, Q8.24)
//  row      | row_valid/row_stall    | row   (ten rows per item, Q24.40)
//  cfg      | cfg_valid/cfg_ready    | cfg_data (stiffness_scale, Q16.16)
//
// Nine front stages (cofactors, det, d-1, scale products, energy) feed a row
// sequencer that issues one row a cycle, unless the row channel stalls, into
// a three-stage lane pipeline and an output register. Products with an
// operand wider than 32 bits are split into 33x33 partial products that are
// summed in the following stage. An item holds the row sequencer for its ten
// rows; the next item is taken as the last row of the current one issues.
// Reset clears all valid bits and loads scale 1.0. Stalls freeze stages.
module volume_energy_stress_hessian_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  vesh_pkg::in_item_t   item,
	output logic                 row_valid,
	input  logic                 row_stall,
	output vesh_pkg::out_item_t  row,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);
	import vesh_pkg::*;

	logic [31:0] scale_q;
	logic signed [32:0] sc_c;
	logic adv, fadv, h_take;

	// front pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [31:0] f_s1 [9], f_s2 [9], f_s3 [9], f_s4 [9], f_s5 [9];
	logic signed [31:0] f_s6 [9], f_s7 [9], f_s8 [9], f_s9 [9];
	logic signed [63:0] pa_s2 [9], pb_s2 [9];
	logic signed [63:0] c_s3 [9], c_s4 [9], c_s5 [9], c_s6 [9];
	logic signed [63:0] c_s7 [9], c_s8 [9], c_s9 [9];
	logic signed [65:0] dph_s4 [3], dpl_s4 [3];
	logic signed [63:0] dm1_s5;
	logic signed [65:0] qhh_s6, qhl_s6, qll_s6, sdh_s6, sdl_s6;
	logic signed [63:0] e2_s7, se_s7, se_s8, se_s9, en_s9;
	logic signed [65:0] eh_s8, el_s8;

	// row sequencer
	logic        h_q;
	logic [3:0]  cnt_q;
	logic signed [31:0] f_hq [9];
	logic signed [63:0] c_hq [9];
	logic signed [63:0] se_hq, en_hq;

	// lane pipeline
	logic v_r1, v_r2, v_r3;
	logic [3:0] row_r1, row_r2, row_r3;
	logic signed [63:0] en_r1, en_r2, en_r3;
	logic signed [65:0] hh_r1 [9], hl_r1 [9], lh_r1 [9], ll_r1 [9];
	logic signed [65:0] sh_r1 [9], sl_r1 [9];
	logic t1en_r1 [9];
	logic signed [63:0] t1_r2 [9], cc_r2 [9], t1_r3 [9];
	logic signed [65:0] mh_r3 [9], ml_r3 [9];
	logic signed [63:0] opa_c;
	logic signed [32:0] fv_c [9];
	logic t1en_c [9];
	logic signed [63:0] val_c [9];
	logic [1:0] ri_c, rj_c;
	logic [3:0] rsel_c;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	assign sc_c = signed'({1'b0, scale_q});

	// flow control
	assign adv        = !row_valid || !row_stall;
	assign h_take     = adv && (!h_q || cnt_q == LAST_ROW);
	assign fadv       = !v_s9 || h_take;
	assign item_stall = !fadv;

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (fadv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (fadv) begin
			f_s1[0] <= item.f_r0c0;
			f_s1[1] <= item.f_r0c1;
			f_s1[2] <= item.f_r0c2;
			f_s1[3] <= item.f_r1c0;
			f_s1[4] <= item.f_r1c1;
			f_s1[5] <= item.f_r1c2;
			f_s1[6] <= item.f_r2c0;
			f_s1[7] <= item.f_r2c1;
			f_s1[8] <= item.f_r2c2;
		end
	end

	// stages 2..3: minor products and cofactors
	for (genvar n = 0; n < 9; n++) begin : g_cof
		localparam int I  = n / 3;
		localparam int J  = n % 3;
		localparam int I1 = (I + 1) % 3;
		localparam int I2 = (I + 2) % 3;
		localparam int J1 = (J + 1) % 3;
		localparam int J2 = (J + 2) % 3;
		always_ff @(posedge clk) begin
			if (fadv) begin
				pa_s2[n] <= 64'(f_s1[I1*3+J1]) * 64'(f_s1[I2*3+J2]);
				pb_s2[n] <= 64'(f_s1[I1*3+J2]) * 64'(f_s1[I2*3+J1]);
				c_s3[n]  <= sat128(128'(pa_s2[n]) - 128'(pb_s2[n]));
			end
		end
	end

	// F and cofactors travel with the item
	always_ff @(posedge clk) begin
		if (fadv) begin
			f_s2 <= f_s1;
			f_s3 <= f_s2;
			f_s4 <= f_s3;
			f_s5 <= f_s4;
			f_s6 <= f_s5;
			f_s7 <= f_s6;
			f_s8 <= f_s7;
			f_s9 <= f_s8;
			c_s4 <= c_s3;
			c_s5 <= c_s4;
			c_s6 <= c_s5;
			c_s7 <= c_s6;
			c_s8 <= c_s7;
			c_s9 <= c_s8;
		end
	end

	// stages 4..9: determinant, d-1, scaled terms, energy
	always_ff @(posedge clk) begin
		if (fadv) begin
			for (int j = 0; j < 3; j++) begin
				dph_s4[j] <= mul33(33'(f_s3[j]), hi33(c_s3[j]));
				dpl_s4[j] <= mul33(33'(f_s3[j]), lo33(c_s3[j]));
			end
			dm1_s5 <= sat128(rnd128(join2(dph_s4[0], dpl_s4[0])
				+ join2(dph_s4[1], dpl_s4[1]) + join2(dph_s4[2], dpl_s4[2])
				- (128'sd1 <<< 72), 32));
			qhh_s6 <= mul33(hi33(dm1_s5), hi33(dm1_s5));
			qhl_s6 <= mul33(hi33(dm1_s5), lo33(dm1_s5));
			qll_s6 <= mul33(lo33(dm1_s5), lo33(dm1_s5));
			sdh_s6 <= mul33(sc_c, hi33(dm1_s5));
			sdl_s6 <= mul33(sc_c, lo33(dm1_s5));
			e2_s7  <= sat128(rnd128(join4(qhh_s6, qhl_s6, qhl_s6, qll_s6), 40));
			se_s7  <= sat128(rnd128(join2(sdh_s6, sdl_s6), 16));
			eh_s8  <= mul33(hi33(e2_s7), sc_c);
			el_s8  <= mul33(lo33(e2_s7), sc_c);
			se_s8  <= se_s7;
			en_s9  <= sat128(rnd128(join2(eh_s8, el_s8), 17));
			se_s9  <= se_s8;
		end
	end

	// row sequencer: holds one item, issues ten rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= 1'b0;
			cnt_q <= STRESS_ROW;
		end else if (h_take) begin
			h_q   <= v_s9;
			cnt_q <= STRESS_ROW;
		end else if (adv && h_q) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (h_take) begin
			f_hq  <= f_s9;
			c_hq  <= c_s9;
			se_hq <= se_s9;
			en_hq <= en_s9;
		end
	end

	// row/column of the Hessian row being issued, and the shared operand
	always_comb begin
		rsel_c = (cnt_q == STRESS_ROW) ? 4'd0 : cnt_q - 4'd1;
		case (rsel_c)
			4'd0: begin ri_c = 2'd0; rj_c = 2'd0; end
			4'd1: begin ri_c = 2'd0; rj_c = 2'd1; end
			4'd2: begin ri_c = 2'd0; rj_c = 2'd2; end
			4'd3: begin ri_c = 2'd1; rj_c = 2'd0; end
			4'd4: begin ri_c = 2'd1; rj_c = 2'd1; end
			4'd5: begin ri_c = 2'd1; rj_c = 2'd2; end
			4'd6: begin ri_c = 2'd2; rj_c = 2'd0; end
			4'd7: begin ri_c = 2'd2; rj_c = 2'd1; end
			default: begin ri_c = 2'd2; rj_c = 2'd2; end
		endcase
		opa_c = (cnt_q == STRESS_ROW) ? se_hq : c_hq[rsel_c];
	end

	// signed F entry for the second-derivative term of each lane
	always_comb begin
		logic [1:0] k, l, m, nn;
		logic [3:0] fidx;
		for (int L = 0; L < 9; L++) begin
			k  = 2'(L / 3);
			l  = 2'(L % 3);
			m  = 2'(3 - ri_c - k);
			nn = 2'(3 - rj_c - l);
			t1en_c[L] = (cnt_q != STRESS_ROW) && (ri_c != k) && (rj_c != l);
			fidx = t1en_c[L] ? ({2'd0, m} * 4'd3 + {2'd0, nn}) : 4'd0;
			fv_c[L] = ((k == next3(ri_c)) == (l == next3(rj_c)))
				? 33'(f_hq[fidx]) : -33'(f_hq[fidx]);
		end
	end

	// lane pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_r1, v_r2, v_r3, row_valid} <= '0;
		end else if (adv) begin
			v_r1      <= h_q;
			v_r2      <= v_r1;
			v_r3      <= v_r2;
			row_valid <= v_r3;
		end
	end

	// final combine for each lane
	always_comb begin
		for (int L = 0; L < 9; L++) begin
			if (row_r3 == STRESS_ROW) begin
				val_c[L] = t1_r3[L];
			end else begin
				val_c[L] = sat128(128'(t1_r3[L])
					+ 128'(sat128(rnd128(join2(mh_r3[L], ml_r3[L]), 16))));
			end
		end
	end

	// lane stages and output register
	always_ff @(posedge clk) begin
		if (adv) begin
			// r1: partial products
			row_r1  <= cnt_q;
			en_r1   <= en_hq;
			t1en_r1 <= t1en_c;
			for (int L = 0; L < 9; L++) begin
				hh_r1[L] <= mul33(hi33(opa_c), hi33(c_hq[L]));
				hl_r1[L] <= mul33(hi33(opa_c), lo33(c_hq[L]));
				lh_r1[L] <= mul33(lo33(opa_c), hi33(c_hq[L]));
				ll_r1[L] <= mul33(lo33(opa_c), lo33(c_hq[L]));
				sh_r1[L] <= mul33(hi33(se_hq), fv_c[L]);
				sl_r1[L] <= mul33(lo33(se_hq), fv_c[L]);
			end
			// r2: stress or first Hessian term, cofactor product
			row_r2 <= row_r1;
			en_r2  <= en_r1;
			for (int L = 0; L < 9; L++) begin
				if (row_r1 == STRESS_ROW) begin
					t1_r2[L] <= sat128(rnd128(join4(hh_r1[L], hl_r1[L], lh_r1[L],
						ll_r1[L]), 48));
				end else begin
					t1_r2[L] <= t1en_r1[L]
						? sat128(rnd128(join2(sh_r1[L], sl_r1[L]), 24)) : 64'sd0;
				end
				cc_r2[L] <= sat128(rnd128(join4(hh_r1[L], hl_r1[L], lh_r1[L],
					ll_r1[L]), 56));
			end
			// r3: scale the cofactor product
			row_r3 <= row_r2;
			en_r3  <= en_r2;
			t1_r3  <= t1_r2;
			for (int L = 0; L < 9; L++) begin
				mh_r3[L] <= mul33(hi33(cc_r2[L]), sc_c);
				ml_r3[L] <= mul33(lo33(cc_r2[L]), sc_c);
			end
			row.row_index <= row_r3;
			row.val0 <= val_c[0];
			row.val1 <= val_c[1];
			row.val2 <= val_c[2];
			row.val3 <= val_c[3];
			row.val4 <= val_c[4];
			row.val5 <= val_c[5];
			row.val6 <= val_c[6];
			row.val7 <= val_c[7];
			row.val8 <= val_c[8];
			row.energy   <= (row_r3 == STRESS_ROW) ? en_r3 : 64'sd0;
			row.last_row <= (row_r3 == LAST_ROW);
		end
	end

	// checks
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.last_row |-> row.row_index == LAST_ROW)
		else $error("last row flag on wrong row");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		h_q |-> cnt_q <= LAST_ROW)
		else $error("row counter out of range");
	a_en: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.row_index != STRESS_ROW |-> row.energy == 64'sd0)
		else $error("energy on Hessian row");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s9 |-> !item_stall)
		else $error("intake stalled with empty front");

endmodule
